[rtl/hsc_pkg.sv]
package hsc_pkg;

	localparam int CHAN_W       = 3;
	localparam int CMD_FIELD_W  = 32;
	localparam int TIME_W       = 64;
	localparam int CHANNELS_DEF = 8;
	localparam int CMD_BITS_DEF = 32;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = {TIME_W{1'b1}};

	typedef enum logic [1:0] {
		PH_READY   = 2'd0,
		PH_SENDING = 2'd1,
		PH_DONE    = 2'd2,
		PH_ERROR   = 2'd3
	} phase_t;

	// per-channel write controls from the update logic to the channel table
	typedef struct packed {
		logic   wr;
		phase_t phase;
		logic   take_cmd;  // latch command, record start time
		logic   drop_cmd;  // clear latch and ack
		logic   give_ack;  // ack <= command
	} upd_t;

endpackage

[rtl/hsc_if.sv]
interface hsc_req_if;
	import hsc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CHAN_W-1:0]      channel;
	logic [CMD_FIELD_W-1:0] command;
	logic [CMD_FIELD_W-1:0] clear_trigger;
	logic [TIME_W-1:0]      now;

	modport source(output valid, channel, command, clear_trigger, now, input ready);
	modport sink(input valid, channel, command, clear_trigger, now, output ready);
endinterface

interface hsc_rsp_if;
	import hsc_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CHAN_W-1:0]      out_channel;
	logic [1:0]             phase;
	logic [CMD_FIELD_W-1:0] ack;

	modport source(output valid, out_channel, phase, ack, input ready);
	modport sink(input valid, out_channel, phase, ack, output ready);
endinterface

[rtl/hsc_table.sv]
module hsc_table #(
	parameter int CHANNELS = hsc_pkg::CHANNELS_DEF,
	parameter int CMD_W    = hsc_pkg::CMD_BITS_DEF,
	parameter int IDX_W    = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [IDX_W-1:0]          idx,
	input  hsc_pkg::upd_t             upd,
	input  logic [CMD_W-1:0]          cmd,
	input  logic [hsc_pkg::TIME_W-1:0] now,
	output hsc_pkg::phase_t           rd_phase,
	output logic [CMD_W-1:0]          rd_latch,
	output logic [hsc_pkg::TIME_W-1:0] rd_start,
	output logic [CMD_W-1:0]          rd_ack
);
	import hsc_pkg::*;

	phase_t            phase_q [CHANNELS];
	logic [CMD_W-1:0]  latch_q [CHANNELS];
	logic [TIME_W-1:0] start_q [CHANNELS];
	logic [CMD_W-1:0]  ack_q   [CHANNELS];

	assign rd_phase = phase_q[idx];
	assign rd_latch = latch_q[idx];
	assign rd_start = start_q[idx];
	assign rd_ack   = ack_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				phase_q[i] <= PH_READY;
				latch_q[i] <= '0;
				start_q[i] <= '0;
				ack_q[i]   <= '0;
			end
		end else if (upd.wr) begin
			phase_q[idx] <= upd.phase;
			if (upd.take_cmd) begin
				latch_q[idx] <= cmd;
				start_q[idx] <= now;
			end
			if (upd.drop_cmd) begin
				latch_q[idx] <= '0;
				ack_q[idx]   <= '0;
			end
			if (upd.give_ack) begin
				ack_q[idx] <= cmd;
			end
		end
	end

endmodule

[rtl/hsc_next.sv]
module hsc_next #(
	parameter int CMD_W = hsc_pkg::CMD_BITS_DEF
) (
	input  logic                       fire,
	input  logic                       in_range,
	input  hsc_pkg::phase_t            phase,
	input  logic [CMD_W-1:0]           latch,
	input  logic [hsc_pkg::TIME_W-1:0] start,
	input  logic [CMD_W-1:0]           ack,
	input  logic [CMD_W-1:0]           cmd,
	input  logic [hsc_pkg::CMD_FIELD_W-1:0] clr,
	input  logic [hsc_pkg::TIME_W-1:0] now,
	input  logic [hsc_pkg::TIME_W-1:0] timeout_ticks,
	output hsc_pkg::upd_t              upd,
	output hsc_pkg::phase_t            res_phase,
	output logic [CMD_W-1:0]           res_ack
);
	import hsc_pkg::*;

	logic [TIME_W-1:0] elapsed;
	logic              expired;
	logic              changed;
	logic              falling;
	phase_t            nxt;

	assign elapsed = now - start;  // wraps mod 2^64
	assign expired = elapsed > timeout_ticks;
	assign changed = cmd != latch;
	assign falling = changed && (latch != '0) && (cmd == '0);

	always_comb begin
		nxt = phase;
		case (phase)
			PH_READY: begin
				if (changed && latch == '0) nxt = PH_SENDING;
			end
			PH_SENDING: begin
				if (expired || changed) nxt = PH_ERROR;
				else if (clr == '0)     nxt = PH_DONE;
			end
			PH_DONE: begin
				if (expired)      nxt = PH_ERROR;
				else if (falling) nxt = PH_READY;
				else if (changed) nxt = PH_ERROR;
			end
			PH_ERROR: begin
				if (falling) nxt = PH_READY;
			end
			default: nxt = phase;
		endcase
	end

	always_comb begin
		upd.wr       = fire && in_range;
		upd.phase    = nxt;
		upd.take_cmd = (phase == PH_READY) && (nxt == PH_SENDING);
		upd.drop_cmd = (phase != PH_READY) && (nxt == PH_READY);
		upd.give_ack = (phase == PH_SENDING) && (nxt == PH_DONE);

		if (!in_range) begin
			res_phase = PH_READY;
			res_ack   = '0;
		end else begin
			res_phase = nxt;
			if (upd.drop_cmd)      res_ack = '0;
			else if (upd.give_ack) res_ack = cmd;
			else                   res_ack = ack;
		end
	end

endmodule

[rtl/handshake_slave_channels_unit.sv]
// Slave side of a command/acknowledge handshake for up to CHANNELS channels.
// Each request carries one channel's sample (command, clear trigger, timer
// count) and yields exactly one response with that channel's new phase
// (0 ready, 1 sending, 2 done, 3 error) and its ack word. One request is
// taken per clock while the response side does not stall; a request passes an
// input register and then a result register before its response is presented.
// The per-channel state sits in flip-flops and is read and updated in the
// single stage between, so a request for the same channel in the next cycle
// already sees the update. timeout_ticks is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while no request is in flight, as
// the block itself does not enforce it. It resets to all ones. Only the low
// CMD_BITS bits of the command are used, and a channel number at or above
// CHANNELS leaves all state alone and reports ready with ack zero.
module handshake_slave_channels_unit #(
	parameter int CHANNELS = hsc_pkg::CHANNELS_DEF,
	parameter int CMD_BITS = hsc_pkg::CMD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [hsc_pkg::TIME_W-1:0] cfg_wr_data,
	hsc_req_if.sink                    req,
	hsc_rsp_if.source                  rsp
);
	import hsc_pkg::*;

	localparam int CMD_W = (CMD_BITS < CMD_FIELD_W) ? CMD_BITS : CMD_FIELD_W;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [TIME_W-1:0]      timeout_q;

	logic                   v_s1;
	logic [CHAN_W-1:0]      chan_s1;
	logic [CMD_W-1:0]       cmd_s1;
	logic [CMD_FIELD_W-1:0] clr_s1;
	logic [TIME_W-1:0]      now_s1;

	logic                   v_s2;
	logic [CHAN_W-1:0]      chan_s2;
	phase_t                 phase_s2;
	logic [CMD_W-1:0]       ack_s2;

	logic                   adv;
	logic                   in_range;
	logic [IDX_W-1:0]       idx;
	upd_t                   upd;
	phase_t                 rd_phase;
	logic [CMD_W-1:0]       rd_latch;
	logic [TIME_W-1:0]      rd_start;
	logic [CMD_W-1:0]       rd_ack;
	phase_t                 res_phase;
	logic [CMD_W-1:0]       res_ack;

	assign adv       = v_s1 && (!v_s2 || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign in_range  = 32'(chan_s1) < CHANNELS;
	assign idx       = IDX_W'(chan_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req.ready) v_s1 <= req.valid;
			if (adv)            v_s2 <= 1'b1;
			else if (rsp.ready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			chan_s1 <= req.channel;
			cmd_s1  <= req.command[CMD_W-1:0];
			clr_s1  <= req.clear_trigger;
			now_s1  <= req.now;
		end
		if (adv) begin
			chan_s2  <= chan_s1;
			phase_s2 <= res_phase;
			ack_s2   <= res_ack;
		end
	end

	hsc_table #(
		.CHANNELS (CHANNELS),
		.CMD_W    (CMD_W),
		.IDX_W    (IDX_W)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.idx      (idx),
		.upd      (upd),
		.cmd      (cmd_s1),
		.now      (now_s1),
		.rd_phase (rd_phase),
		.rd_latch (rd_latch),
		.rd_start (rd_start),
		.rd_ack   (rd_ack)
	);

	hsc_next #(
		.CMD_W (CMD_W)
	) u_next (
		.fire          (adv),
		.in_range      (in_range),
		.phase         (rd_phase),
		.latch         (rd_latch),
		.start         (rd_start),
		.ack           (rd_ack),
		.cmd           (cmd_s1),
		.clr           (clr_s1),
		.now           (now_s1),
		.timeout_ticks (timeout_q),
		.upd           (upd),
		.res_phase     (res_phase),
		.res_ack       (res_ack)
	);

	assign rsp.valid       = v_s2;
	assign rsp.out_channel = chan_s2;
	assign rsp.phase       = phase_s2;
	assign rsp.ack         = CMD_FIELD_W'(ack_s2);

`ifndef SYNTHESIS
	// an accepted request always lands in the input register
	a_req_lands: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("accepted request not captured");

	// ready is only reached with the ack cleared
	a_ready_no_ack: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.phase == PH_READY |-> rsp.ack == '0)
		else $error("ready phase with nonzero ack");

	// done means the ack mirrors the unchanged command
	a_done_ack: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_range && res_phase == PH_DONE |-> res_ack == cmd_s1)
		else $error("done phase with ack different from command");

	// unknown channel reports ready and zero ack
	a_bad_chan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !(32'(rsp.out_channel) < CHANNELS)
			|-> rsp.phase == PH_READY && rsp.ack == '0)
		else $error("out-of-range channel reported state");
`endif

endmodule

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hsc_pkg::*;

	localparam int CHANNELS = CHANNELS_DEF;
	localparam int CMD_BITS = CMD_BITS_DEF;
	localparam logic [CMD_FIELD_W-1:0] CMD_MASK =
		(CMD_BITS >= CMD_FIELD_W) ? '1 : CMD_FIELD_W'((64'd1 << CMD_BITS) - 64'd1);
	localparam int ITEMS_PER_SETTING = 265;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [CHAN_W-1:0]      channel;
		phase_t                 phase;
		logic [CMD_FIELD_W-1:0] ack;
	} report_t;

	// per-channel handshake state, updated as each request is accepted
	class slave_channel_model;
		logic [TIME_W-1:0]      timeout_ticks;
		phase_t                 phase_of [CHANNELS];
		logic [CMD_FIELD_W-1:0] latched  [CHANNELS];
		logic [TIME_W-1:0]      start_at [CHANNELS];
		logic [CMD_FIELD_W-1:0] ack_word [CHANNELS];
		report_t                expected_reports [$];
		int unsigned            failures;
		int unsigned            reports_checked;

		function new();
			timeout_ticks = TIMEOUT_RESET;
			failures = 0;
			reports_checked = 0;
			for (int i = 0; i < CHANNELS; i++) begin
				phase_of[i] = PH_READY;
				latched[i]  = '0;
				start_at[i] = '0;
				ack_word[i] = '0;
			end
		endfunction

		function void take_sample(logic [CHAN_W-1:0] ch, logic [CMD_FIELD_W-1:0] cmd_in,
				logic [CMD_FIELD_W-1:0] clr, logic [TIME_W-1:0] at);
			report_t                rep;
			logic [CMD_FIELD_W-1:0] cmd;
			logic [CMD_FIELD_W-1:0] prev;
			logic [TIME_W-1:0]      elapsed;
			phase_t                 ph;
			bit                     changed;
			bit                     falling;
			bit                     timed_out;
			cmd = cmd_in & CMD_MASK;
			rep.channel = ch;
			if (ch >= CHANNELS) begin
				rep.phase = PH_READY;
				rep.ack = '0;
				expected_reports.push_back(rep);
				return;
			end
			prev = latched[ch];
			ph = phase_of[ch];
			elapsed = at - start_at[ch];  // wraps mod 2^64
			changed = (cmd != prev);
			falling = changed && prev != '0 && cmd == '0;
			timed_out = elapsed > timeout_ticks;
			case (ph)
				PH_ERROR: begin
					if (falling) begin
						ph = PH_READY;
						ack_word[ch] = '0;
						latched[ch] = '0;
					end
				end
				PH_READY: begin
					if (changed && prev == '0) begin
						latched[ch] = cmd;
						start_at[ch] = at;
						ph = PH_SENDING;
					end
				end
				PH_SENDING: begin
					if (timed_out || changed) begin
						ph = PH_ERROR;
					end else if (clr == '0) begin
						ack_word[ch] = cmd;
						ph = PH_DONE;
					end
				end
				default: begin
					if (timed_out) begin
						ph = PH_ERROR;
					end else if (falling) begin
						ack_word[ch] = '0;
						latched[ch] = '0;
						ph = PH_READY;
					end else if (changed) begin
						ph = PH_ERROR;
					end
				end
			endcase
			phase_of[ch] = ph;
			rep.phase = ph;
			rep.ack = ack_word[ch];
			expected_reports.push_back(rep);
		endfunction

		function void check_report(logic [CHAN_W-1:0] ch, logic [1:0] ph,
				logic [CMD_FIELD_W-1:0] ack);
			report_t exp_rep;
			if (expected_reports.size() == 0) begin
				$error("response with nothing outstanding: channel %0d phase %0d ack %h",
					ch, ph, ack);
				failures++;
				return;
			end
			exp_rep = expected_reports.pop_front();
			reports_checked++;
			if (ch !== exp_rep.channel) begin
				$error("out_channel: expected %0d, got %0d", exp_rep.channel, ch);
				failures++;
			end
			if (ph !== exp_rep.phase) begin
				$error("phase: expected %0d, got %0d", exp_rep.phase, ph);
				failures++;
			end
			if (ack !== exp_rep.ack) begin
				$error("ack: expected %h, got %h", exp_rep.ack, ack);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return expected_reports.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [TIME_W-1:0] cfg_wr_data;
	logic [TIME_W-1:0] clock_now;
	int unsigned       cycle_count = 0;
	int unsigned       req_burst_left = 0;

	slave_channel_model model = new();

	hsc_req_if req_if();
	hsc_rsp_if rsp_if();

	handshake_slave_channels_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_if),
		.rsp         (rsp_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			model.check_report(rsp_if.out_channel, rsp_if.phase, rsp_if.ack);
	end

	// response side back-pressure: short stalls, some long ones, free-running stretches,
	// and one long hold while requests keep coming
	initial begin : rsp_pacing
		int unsigned stall_left;
		int unsigned run_left;
		int unsigned r;
		bit          held_once;
		stall_left = 0;
		run_left = 0;
		held_once = 1'b0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_once && model.reports_checked >= 300) begin
				held_once = 1'b1;
				rsp_if.ready = 1'b0;
				repeat (400) @(negedge clk);
			end else if (run_left > 0) begin
				run_left--;
				rsp_if.ready = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready = 1'b0;
			end else begin
				r = $urandom_range(0, 999);
				if (r < 4) begin
					run_left = $urandom_range(100, 300);
					rsp_if.ready = 1'b1;
				end else if (r < 150) begin
					stall_left = $urandom_range(0, 2);
					rsp_if.ready = 1'b0;
				end else if (r < 175) begin
					stall_left = $urandom_range(10, 40);
					rsp_if.ready = 1'b0;
				end else begin
					rsp_if.ready = 1'b1;
				end
			end
		end
	end

	function automatic int unsigned req_gap();
		int unsigned r;
		if (req_burst_left > 0) begin
			req_burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			req_burst_left = $urandom_range(50, 200);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge; returns at a falling edge after acceptance, once any random gap has passed
	task automatic offer(input logic [CHAN_W-1:0] ch, input logic [CMD_FIELD_W-1:0] cmd,
			input logic [CMD_FIELD_W-1:0] clr, input logic [TIME_W-1:0] at);
		int unsigned gap;
		req_if.valid = 1'b1;
		req_if.channel = ch;
		req_if.command = cmd;
		req_if.clear_trigger = clr;
		req_if.now = at;
		do
			@(posedge clk);
		while (!req_if.ready);
		model.take_sample(ch, cmd, clr, at);
		@(negedge clk);
		gap = req_gap();
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		req_if.valid = 1'b0;
		while (model.pending() != 0)
			@(negedge clk);
	endtask

	task automatic set_timeout(input logic [TIME_W-1:0] ticks);
		drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = ticks;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		model.timeout_ticks = ticks;
	endtask

	task automatic directed_checks();
		// full-scale command and a start time at the top of the timer, then wrap
		offer(3'd0, 32'h0000_0000, 32'h0000_0000, 64'd0);
		offer(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
		offer(3'd0, 32'hFFFF_FFFF, 32'h0000_0001, 64'd5);
		offer(3'd0, 32'hFFFF_FFFF, 32'h0000_0000, 64'd6);
		offer(3'd0, 32'hFFFF_FFFF, 32'h0000_0000, 64'd7);
		offer(3'd0, 32'h0000_0000, 32'h0000_0000, 64'd8);
		// command change while sending, stuck in error, then release
		offer(3'd1, 32'h0000_0001, 32'h0000_0001, 64'd9);
		offer(3'd1, 32'h0000_0002, 32'h0000_0000, 64'd10);
		offer(3'd1, 32'h0000_0003, 32'h0000_0000, 64'd11);
		offer(3'd1, 32'h0000_0000, 32'h0000_0000, 64'd12);
		// command change after done
		offer(3'd2, 32'h8000_0000, 32'h0000_0000, 64'd13);
		offer(3'd2, 32'h8000_0000, 32'h0000_0000, 64'd14);
		offer(3'd2, 32'h8000_0001, 32'h0000_0000, 64'd15);
		offer(3'd2, 32'h0000_0000, 32'h0000_0000, 64'd16);
		// drop to zero while still sending is a change, not a release
		offer(3'd7, 32'h1234_5678, 32'h0000_0000, 64'd17);
		offer(3'd7, 32'h0000_0000, 32'h0000_0000, 64'd18);
		offer(3'd7, 32'h0000_0000, 32'h0000_0000, 64'd19);
		// timeout exactly at the limit passes, one past fails, and wins over clear/release
		set_timeout(64'd5);
		offer(3'd3, 32'h0000_00A5, 32'h0000_0007, 64'd100);
		offer(3'd3, 32'h0000_00A5, 32'h0000_0007, 64'd105);
		offer(3'd3, 32'h0000_00A5, 32'h0000_0000, 64'd106);
		offer(3'd4, 32'h0000_005A, 32'h0000_0000, 64'd200);
		offer(3'd4, 32'h0000_005A, 32'h0000_0000, 64'd201);
		offer(3'd4, 32'h0000_0000, 32'h0000_0000, 64'd206);
		set_timeout(64'd0);
		offer(3'd5, 32'h0000_0009, 32'h0000_0000, 64'd50);
		offer(3'd5, 32'h0000_0009, 32'h0000_0000, 64'd50);
	endtask

	function automatic logic [CMD_FIELD_W-1:0] pick_command();
		logic [CMD_FIELD_W-1:0] c;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			c = '1;
		else if (r < 20)
			c = 32'd1 << $urandom_range(0, 31);
		else
			c = $urandom;
		if (c == '0)
			c = 32'd1;
		return c;
	endfunction

	task automatic random_sample();
		logic [CHAN_W-1:0]      ch;
		logic [CMD_FIELD_W-1:0] cmd;
		logic [CMD_FIELD_W-1:0] clr;
		logic [CMD_FIELD_W-1:0] held;
		int unsigned            r;
		r = $urandom_range(0, 99);
		if (r < 70)
			clock_now = clock_now + $urandom_range(0, 3);
		else if (r < 90)
			clock_now = clock_now + $urandom_range(4, 60);
		else if (r < 97)
			clock_now = clock_now + $urandom_range(61, 5000);
		else
			clock_now = {$urandom, $urandom};
		ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
		held = model.latched[ch];
		clr = ($urandom_range(0, 99) < 30) ? 32'd0 : $urandom;
		r = $urandom_range(0, 99);
		case (model.phase_of[ch])
			PH_READY:   cmd = (r < 80) ? pick_command() : '0;
			PH_SENDING: begin
				cmd = (r < 10) ? pick_command() : held;
				if ($urandom_range(0, 99) < 45)
					clr = '0;
			end
			PH_DONE:    cmd = (r < 55) ? '0 : (r < 90) ? held : pick_command();
			default:    cmd = (r < 65) ? '0 : pick_command();
		endcase
		offer(ch, cmd, clr, clock_now);
	endtask

	initial begin : stimulus
		logic [TIME_W-1:0] settings [6];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_if.valid = 1'b0;
		req_if.channel = '0;
		req_if.command = '0;
		req_if.clear_trigger = '0;
		req_if.now = '0;
		clock_now = '0;
		settings[0] = 64'd20;
		settings[1] = 64'd0;
		settings[2] = {$urandom, $urandom};
		settings[3] = 64'd300;
		settings[4] = 64'd3;
		settings[5] = TIMEOUT_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_checks();

		foreach (settings[s]) begin
			set_timeout(settings[s]);
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				if (s == 2 && n == ITEMS_PER_SETTING / 2)
					drain();
				random_sample();
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (model.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
rtl/hsc_pkg.sv
rtl/hsc_if.sv
rtl/hsc_table.sv
rtl/hsc_next.sv
rtl/handshake_slave_channels_unit.sv
tb/testbench.sv
